// ===== sv/assert_macros.svh =====
// Assertion macros used by crtc_scanline_row_address.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/crtc_sra_pkg.sv =====
// Types and constants of the CRT vertical timing and row address block.
`default_nettype none

package crtc_sra_pkg;

    localparam int ADDR_BITS = 12;
    localparam int LINE_BITS = 9;
    localparam int CL_BITS   = 4;
    // Two extra bits so sums of line counts and config values do not overflow.
    localparam int SUM_BITS  = LINE_BITS + 2;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [LINE_BITS-1:0] t_line;
    typedef logic [SUM_BITS-1:0]  t_sum;

    // item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_LOAD = 2'd1;
    localparam logic [1:0] KIND_RISE = 2'd2;

    // register load selects
    localparam logic [1:0] SEL_NONE   = 2'd0;
    localparam logic [1:0] SEL_TOP    = 2'd1;
    localparam logic [1:0] SEL_ROW    = 2'd2;
    localparam logic [1:0] SEL_CURSOR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAR_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIDEO_LINES = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VBLANK_LINES = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VSYNC_DELAY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VSYNC_LINES = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VBLANK_STOP = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHARS_PER_ROW = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE_BITS = 3'd7;

    // configuration reset values
    localparam logic [4:0] RST_CHAR_HEIGHT   = 5'd10;
    localparam logic [8:0] RST_VIDEO_LINES   = 9'd240;
    localparam logic [6:0] RST_VBLANK_LINES  = 7'd20;
    localparam logic [6:0] RST_VSYNC_DELAY   = 7'd4;
    localparam logic [6:0] RST_VSYNC_LINES   = 7'd10;
    localparam logic [6:0] RST_VBLANK_STOP   = 7'd1;
    localparam logic [7:0] RST_CHARS_PER_ROW = 8'd80;
    localparam logic [2:0] RST_MODE_BITS     = 3'd6;

    // mode bit positions
    localparam int MODE_LOAD_FIRST = 0;
    localparam int MODE_VSYNC_POL  = 1;
    localparam int MODE_VBLANK_POL = 2;

    localparam logic [4:0] MAX_HEIGHT = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  reg_select;
        logic [11:0] load_address;
    } t_in;

    typedef struct packed {
        logic [8:0]  scan_line;
        logic [3:0]  char_line;
        logic [11:0] row_address;
        logic [11:0] next_row_address;
        logic [11:0] top_address;
        logic [11:0] cursor_address;
        logic        vsync_level;
        logic        vblank_level;
        logic        recirculate_enable;
        logic        line_rate_clock;
        logic        row_clock;
    } t_out;

endpackage

`default_nettype wire

// ===== sv/crtc_scanline_row_address.sv =====
// The result of each accepted transaction is registered in the output register.
// Throughput: one transaction per cycle while results are taken; the output register accepts a new result
// in the same cycle that the previous one is taken.
// All timing, counter and address updates are one combinational pass into state.
// Reset (synchronous, active low) clears counters and address registers, loads the
// default timing values and puts vsync and vblank at their inactive levels.
`default_nettype none

`include "assert_macros.svh"

module crtc_scanline_row_address (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  crtc_sra_pkg::t_in                        i_in,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output crtc_sra_pkg::t_out                       o_out,
    input  logic                                     i_cfg_we,
    input  logic [crtc_sra_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [crtc_sra_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    // configuration
    logic [4:0] r_char_height;
    logic [8:0] r_video_lines;
    logic [6:0] r_vblank_lines;
    logic [6:0] r_vsync_delay;
    logic [6:0] r_vsync_lines;
    logic [6:0] r_vblank_stop;
    logic [7:0] r_chars_per_row;
    logic [2:0] r_mode;

    // timing state
    crtc_sra_pkg::t_line             r_line, n_line;
    logic [crtc_sra_pkg::CL_BITS-1:0] r_cl, n_cl;
    crtc_sra_pkg::t_addr             r_top, n_top;
    crtc_sra_pkg::t_addr             r_row_start, n_row_start;
    crtc_sra_pkg::t_addr             r_cursor, n_cursor;
    crtc_sra_pkg::t_addr             r_cur_row, n_cur_row;
    logic                            r_vsync, n_vsync;
    logic                            r_vblank, n_vblank;
    logic                            r_lrc, n_lrc;
    logic                            r_clc, n_clc;

    logic                            r_out_valid;
    crtc_sra_pkg::t_out              r_out, n_out;

    logic                            w_in_acc;
    logic [4:0]                      w_ch;
    crtc_sra_pkg::t_sum              w_ch_s, w_cur, w_nxt, w_vsl, w_lpf;
    crtc_sra_pkg::t_sum              w_vs_begin, w_vs_end, w_vb_stop;
    logic [4:0]                      w_target;
    logic [crtc_sra_pkg::CL_BITS-1:0] w_tick_cl;
    logic                            w_tick_wrap;
    logic                            w_lbre;
    logic                            w_vs_act, w_vb_act;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // effective character height, clamped to 1..16
    always_comb begin
        if (r_char_height == 5'd0) begin
            w_ch = 5'd1;
        end else if (r_char_height > crtc_sra_pkg::MAX_HEIGHT) begin
            w_ch = crtc_sra_pkg::MAX_HEIGHT;
        end else begin
            w_ch = r_char_height;
        end
    end

    assign w_ch_s     = crtc_sra_pkg::SUM_BITS'(w_ch);
    assign w_cur      = crtc_sra_pkg::SUM_BITS'(r_line);
    assign w_nxt      = w_cur + crtc_sra_pkg::SUM_BITS'(1);
    assign w_vsl      = crtc_sra_pkg::SUM_BITS'(r_video_lines);
    assign w_lpf      = w_vsl + crtc_sra_pkg::SUM_BITS'(r_vblank_lines);
    assign w_vs_begin = w_vsl + crtc_sra_pkg::SUM_BITS'(r_vsync_delay);
    assign w_vs_end   = w_vs_begin + crtc_sra_pkg::SUM_BITS'(r_vsync_lines);
    // vblank stop line compared as nxt + stop == frame length (no negatives)
    assign w_vb_stop  = w_nxt + crtc_sra_pkg::SUM_BITS'(r_vblank_stop);
    assign w_vs_act   = r_mode[crtc_sra_pkg::MODE_VSYNC_POL];
    assign w_vb_act   = r_mode[crtc_sra_pkg::MODE_VBLANK_POL];

    // recirculate is off on the address load scan line
    assign w_target = r_mode[crtc_sra_pkg::MODE_LOAD_FIRST] ? 5'd0 : (w_ch - 5'd1);

    // row wraps at the last scan line, or on the line where the last row starts
    assign w_tick_wrap = !((5'(r_cl) + 5'd1 < w_ch) && (w_cur + w_ch_s != w_lpf));
    assign w_tick_cl   = w_tick_wrap ? '0 : r_cl + crtc_sra_pkg::CL_BITS'(1);
    assign w_lbre      = 5'(w_tick_cl) != w_target;

    always_comb begin
        n_line      = r_line;
        n_cl        = r_cl;
        n_top       = r_top;
        n_row_start = r_row_start;
        n_cursor    = r_cursor;
        n_cur_row   = r_cur_row;
        n_vsync     = r_vsync;
        n_vblank    = r_vblank;
        n_lrc       = r_lrc;
        n_clc       = r_clc;
        case (i_in.kind)
            crtc_sra_pkg::KIND_TICK: begin
                n_lrc = 1'b0;
                n_cl  = w_tick_cl;
                if (w_tick_wrap) begin
                    n_clc = 1'b0;
                end
                if ((w_nxt + w_ch_s >= w_lpf) && (w_nxt < w_lpf)) begin
                    n_cur_row   = r_top;
                    n_row_start = r_top;
                end else if (!w_lbre || (w_nxt >= w_vsl)) begin
                    n_cur_row   = r_row_start;
                    n_row_start = r_row_start + crtc_sra_pkg::ADDR_BITS'(r_chars_per_row);
                end
                if (w_nxt == w_vsl) begin
                    n_vblank = w_vb_act;
                end else if (w_vb_stop == w_lpf) begin
                    n_vblank = !w_vb_act;
                end
                if (w_nxt == w_vs_begin) begin
                    n_vsync = w_vs_act;
                end else if (w_nxt == w_vs_end) begin
                    n_vsync = !w_vs_act;
                end
                if (w_nxt == w_lpf) begin
                    n_line = '0;
                end else begin
                    n_line = w_nxt[crtc_sra_pkg::LINE_BITS-1:0];
                end
            end
            crtc_sra_pkg::KIND_LOAD: begin
                case (i_in.reg_select)
                    crtc_sra_pkg::SEL_TOP: begin
                        n_top = i_in.load_address;
                    end
                    crtc_sra_pkg::SEL_ROW: begin
                        // during vertical blanking a row start load goes to top-of-page
                        if (w_cur >= w_vsl) begin
                            n_top = i_in.load_address;
                        end else begin
                            n_row_start = i_in.load_address;
                        end
                    end
                    crtc_sra_pkg::SEL_CURSOR: begin
                        n_cursor = i_in.load_address;
                    end
                    default: begin
                    end
                endcase
            end
            crtc_sra_pkg::KIND_RISE: begin
                n_lrc = 1'b1;
                if (r_cl == '0) begin
                    n_clc = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.scan_line          = n_line;
        n_out.char_line          = n_cl;
        n_out.row_address        = n_cur_row;
        n_out.next_row_address   = n_row_start;
        n_out.top_address        = n_top;
        n_out.cursor_address     = n_cursor;
        n_out.vsync_level        = n_vsync;
        n_out.vblank_level       = n_vblank;
        n_out.recirculate_enable = 5'(n_cl) != w_target;
        n_out.line_rate_clock    = n_lrc;
        n_out.row_clock          = n_clc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_height   <= crtc_sra_pkg::RST_CHAR_HEIGHT;
            r_video_lines   <= crtc_sra_pkg::RST_VIDEO_LINES;
            r_vblank_lines  <= crtc_sra_pkg::RST_VBLANK_LINES;
            r_vsync_delay   <= crtc_sra_pkg::RST_VSYNC_DELAY;
            r_vsync_lines   <= crtc_sra_pkg::RST_VSYNC_LINES;
            r_vblank_stop   <= crtc_sra_pkg::RST_VBLANK_STOP;
            r_chars_per_row <= crtc_sra_pkg::RST_CHARS_PER_ROW;
            r_mode          <= crtc_sra_pkg::RST_MODE_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crtc_sra_pkg::CFG_CHAR_HEIGHT:   r_char_height   <= i_cfg_data[4:0];
                crtc_sra_pkg::CFG_VIDEO_LINES:   r_video_lines   <= i_cfg_data[8:0];
                crtc_sra_pkg::CFG_VBLANK_LINES:  r_vblank_lines  <= i_cfg_data[6:0];
                crtc_sra_pkg::CFG_VSYNC_DELAY:   r_vsync_delay   <= i_cfg_data[6:0];
                crtc_sra_pkg::CFG_VSYNC_LINES:   r_vsync_lines   <= i_cfg_data[6:0];
                crtc_sra_pkg::CFG_VBLANK_STOP:   r_vblank_stop   <= i_cfg_data[6:0];
                crtc_sra_pkg::CFG_CHARS_PER_ROW: r_chars_per_row <= i_cfg_data[7:0];
                crtc_sra_pkg::CFG_MODE_BITS:     r_mode          <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_cl        <= '0;
            r_top       <= '0;
            r_row_start <= '0;
            r_cursor    <= '0;
            r_cur_row   <= '0;
            r_vsync     <= !crtc_sra_pkg::RST_MODE_BITS[crtc_sra_pkg::MODE_VSYNC_POL];
            r_vblank    <= !crtc_sra_pkg::RST_MODE_BITS[crtc_sra_pkg::MODE_VBLANK_POL];
            r_lrc       <= 1'b1;
            r_clc       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_line      <= n_line;
                r_cl        <= n_cl;
                r_top       <= n_top;
                r_row_start <= n_row_start;
                r_cursor    <= n_cursor;
                r_cur_row   <= n_cur_row;
                r_vsync     <= n_vsync;
                r_vblank    <= n_vblank;
                r_lrc       <= n_lrc;
                r_clc       <= n_clc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    `AST_NEXT(a_result_follows, i_clk, i_rst_n, w_in_acc, r_out_valid,
        "accepted transaction did not produce a result")
    `AST_NEXT(a_tick_lrc_low, i_clk, i_rst_n,
        w_in_acc && (i_in.kind == crtc_sra_pkg::KIND_TICK), !r_lrc && !r_out.line_rate_clock,
        "line rate clock not low after line tick")
    `AST_NEXT(a_char_line_range, i_clk, i_rst_n,
        w_in_acc && (i_in.kind == crtc_sra_pkg::KIND_TICK), 5'(r_cl) < $past(w_ch),
        "scan line within row out of range after tick")

endmodule

`default_nettype wire
